/* src/vlt3d_pkg.sv */
// Shared types and constants for the 3D voxel line walker.
// No dependencies; imported by voxel_line_traversal_3d_unit.
package vlt3d_pkg;

    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned NUM_PAIRS = 6;

    // Command carried in the slave-side tuser
    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_ADVANCE = 1'b1
    } t_mode;

    // Slot of the crossing term (2k_a+1)*d_b for the ordered axis pair a != b
    function automatic logic [2:0] pair_idx(input int unsigned a, input int unsigned b);
        int unsigned idx;
        idx = a * 2 + ((b > a) ? (b - 1) : b);
        return idx[2:0];
    endfunction

endpackage

/* src/voxel_line_traversal_3d_unit.sv */
// 3D voxel line walker (Amanatides-Woo traversal in exact integer form).
// Depends on vlt3d_pkg for the command codes and the crossing-term slot map.
//
// Usage:
//   Slave channel (i_s_axis_*): one word per command. tuser holds the mode:
//   load takes start and end voxels from tdata, advance steps one voxel.
//   Master channel (o_m_axis_*): exactly one word per accepted command.
//   tdata holds the voxel reached, tuser flags a real step, tlast marks the
//   step that lands on the end voxel. Load words, and advances with no line
//   or a finished line, come out with tuser low and all other bits zero.
//   Path: each command word passes the input register, then the result
//   register, whose word drives the master side. Throughput: one word per
//   clock while the receiver keeps tready high; each advance needs only six
//   compares of the running crossing terms and a few adds, all between the
//   input register and the result register.
//   Stall: when the receiver holds tready low, the result register holds
//   its word, the input register keeps accepting until it is full, then
//   tready on the slave side drops. Nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous): drop both pipeline words and forget
//   any loaded line; the next advance before a load gives an invalid word.
//   The start voxel itself is never reported; ties step all tied axes.
module voxel_line_traversal_3d_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Slave side
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata from bit 0: start_x, start_y, start_z, end_x, end_y, end_z, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    // tuser: mode
    input  logic [0:0]                            i_s_axis_tuser,
    // Master side
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata from bit 0: voxel_x, voxel_y, voxel_z, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0]     o_m_axis_tdata,
    // tuser: voxel_valid
    output logic [0:0]                            o_m_axis_tuser,
    // tlast: last_voxel
    output logic                                  o_m_axis_tlast
);
    import vlt3d_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int SW    = COORD_BITS + 1;      // span width
    localparam int TW    = 2 * COORD_BITS + 3;  // crossing-term width
    localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;

    // Input register
    logic          r_s1_valid;
    t_mode         r_s1_mode;
    logic [CW-1:0] r_s1_start [NUM_AXES];
    logic [CW-1:0] r_s1_end   [NUM_AXES];

    // Result register
    logic          r_out_valid;
    logic [CW-1:0] r_out_voxel [NUM_AXES];
    logic          r_out_vld;
    logic          r_out_last;

    // Line state
    logic [CW-1:0] r_cur  [NUM_AXES];
    logic [CW-1:0] r_tgt  [NUM_AXES];
    logic          r_sign [NUM_AXES];
    logic [SW-1:0] r_span [NUM_AXES];
    logic [TW-1:0] r_term [NUM_PAIRS];
    logic          r_active;

    // Next values
    logic          s2_ready;
    logic          s1_fire;
    logic          s_accept;
    logic          mv    [NUM_AXES];
    logic [CW-1:0] n_cur [NUM_AXES];
    logic [TW-1:0] n_term [NUM_PAIRS];
    logic [SW-1:0] n_span [NUM_AXES];
    logic          n_sign [NUM_AXES];
    logic          n_last;
    logic          adv_step;

    assign s2_ready        = !r_out_valid || i_m_axis_tready;
    assign s1_fire         = r_s1_valid && s2_ready;
    assign o_s_axis_tready = !r_s1_valid || s2_ready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign adv_step        = (r_s1_mode == MODE_ADVANCE) && r_active;

    // Load path: span and direction per axis
    always_comb begin
        logic signed [SW-1:0] diff;
        for (int a = 0; a < NUM_AXES; a++) begin
            diff = $signed({r_s1_end[a][CW-1], r_s1_end[a]})
                 - $signed({r_s1_start[a][CW-1], r_s1_start[a]});
            n_span[a] = diff[SW-1] ? SW'(-diff) : SW'(diff);
            n_sign[a] = ($signed(r_s1_start[a]) >= $signed(r_s1_end[a]));
        end
    end

    // Advance path: pick the axes with the earliest crossing, step them
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            mv[a] = 1'b1;
            for (int b = 0; b < NUM_AXES; b++) begin
                if (a != b) begin
                    if (r_term[pair_idx(b, a)] < r_term[pair_idx(a, b)]) begin
                        mv[a] = 1'b0;
                    end
                end
            end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            if (!mv[a]) begin
                n_cur[a] = r_cur[a];
            end else if (r_sign[a]) begin
                n_cur[a] = r_cur[a] - CW'(1);
            end else begin
                n_cur[a] = r_cur[a] + CW'(1);
            end
            for (int b = 0; b < NUM_AXES; b++) begin
                if (a != b) begin
                    n_term[pair_idx(a, b)] = r_term[pair_idx(a, b)]
                        + (mv[a] ? {{(TW-SW-1){1'b0}}, r_span[b], 1'b0} : TW'(0));
                end
            end
        end
        n_last = (n_cur[0] == r_tgt[0]) && (n_cur[1] == r_tgt[1])
              && (n_cur[2] == r_tgt[2]);
    end

    // Input register: take a word whenever it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
        if (s_accept) begin
            r_s1_mode <= t_mode'(i_s_axis_tuser[0]);
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s1_start[a] <= i_s_axis_tdata[a*CW +: CW];
                r_s1_end[a]   <= i_s_axis_tdata[(a+3)*CW +: CW];
            end
        end
    end

    // Line state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                if (r_s1_mode == MODE_LOAD) begin
                    r_active <= !((r_s1_start[0] == r_s1_end[0])
                                && (r_s1_start[1] == r_s1_end[1])
                                && (r_s1_start[2] == r_s1_end[2]));
                end else if (r_active) begin
                    r_active <= !n_last;
                end
            end
        end
        if (s1_fire) begin
            if (r_s1_mode == MODE_LOAD) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_cur[a]  <= r_s1_start[a];
                    r_tgt[a]  <= r_s1_end[a];
                    r_span[a] <= n_span[a];
                    r_sign[a] <= n_sign[a];
                    for (int b = 0; b < NUM_AXES; b++) begin
                        if (a != b) begin
                            r_term[pair_idx(a, b)] <= {{(TW-SW){1'b0}}, n_span[b]};
                        end
                    end
                end
            end else if (r_active) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_cur[a] <= n_cur[a];
                end
                for (int p = 0; p < NUM_PAIRS; p++) begin
                    r_term[p] <= n_term[p];
                end
            end
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out_voxel[a] <= adv_step ? n_cur[a] : CW'(0);
            end
            r_out_vld  <= adv_step;
            r_out_last <= adv_step && n_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_voxel[2], r_out_voxel[1], r_out_voxel[0]});
    assign o_m_axis_tuser  = r_out_vld;
    assign o_m_axis_tlast  = r_out_last;

    // A result without a step carries no voxel and no last mark
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> (o_m_axis_tdata == '0) && !o_m_axis_tlast)
        else $error("invalid result word carries data");

    // Reaching the end voxel ends the line
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && adv_step && n_last |=> !r_active)
        else $error("line still active after last voxel");

    // An active line is never sitting on its end voxel
    a_active_not_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !((r_cur[0] == r_tgt[0]) && (r_cur[1] == r_tgt[1])
                    && (r_cur[2] == r_tgt[2])))
        else $error("active line already at end voxel");

    // Every advance of an active line moves at least one axis
    a_some_axis_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && adv_step |-> (mv[0] || mv[1] || mv[2]))
        else $error("advance moved no axis");

endmodule

/* verif/tb.sv */
// Self-checking testbench for voxel_line_traversal_3d_unit, the 3D voxel line walker.
// Drives load and advance words, predicts every result word in-line, and checks them in order.
// Depends on vlt3d_pkg (t_mode) and the unit under test.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vlt3d_pkg::*;

    localparam int CB           = 16;
    localparam int IN_W         = ((6*CB+7)/8)*8;
    localparam int OUT_W        = ((3*CB+7)/8)*8;
    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 1000;

    localparam logic signed [CB-1:0] CMIN = -32768;
    localparam logic signed [CB-1:0] CMAX = 32767;

    // Line endpoints as carried in slave tdata; sx sits in the lowest bits
    typedef struct packed {
        logic signed [CB-1:0] ez, ey, ex, sz, sy, sx;
    } line_ends_t;

    // One result word: voxel position plus tuser (valid) and tlast (last)
    typedef struct packed {
        logic signed [CB-1:0] x, y, z;
        logic                 valid;
        logic                 last;
    } voxel_word_t;

    typedef struct packed {
        t_mode       mode;
        line_ends_t  ends;
        logic        typed;
        voxel_word_t want;
    } dir_row_t;

    localparam voxel_word_t IDLE_WORD = '0;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // fields from bit 0: start_x, start_y, start_z, end_x, end_y, end_z
    logic [IN_W-1:0]  s_tdata = '0;
    // fields: mode
    logic [0:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // fields from bit 0: voxel_x, voxel_y, voxel_z
    logic [OUT_W-1:0] m_tdata;
    // fields: voxel_valid
    logic [0:0]       m_tuser;
    logic             m_tlast;

    voxel_line_traversal_3d_unit #(.COORD_BITS(CB)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line walk predictor: its own copy of the walker state
    // ------------------------------------------------------------------
    logic signed [CB-1:0] walk_pos [3];
    logic signed [CB-1:0] walk_goal[3];
    logic                 walk_down[3];
    logic [CB:0]          walk_span[3];
    // cross_term[a][b] = (2k_a+1)*span_b, exact
    longint unsigned      cross_term[3][3];
    logic                 walk_live = 1'b0;

    voxel_word_t voxels_due[$];
    int          cmds_sent = 0;
    int          n_errors = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;

    initial begin
        for (int a = 0; a < 3; a++) begin
            walk_pos[a]  = '0;
            walk_goal[a] = '0;
            walk_down[a] = 1'b0;
            walk_span[a] = '0;
            for (int b = 0; b < 3; b++) cross_term[a][b] = 0;
        end
    end

    function automatic voxel_word_t walk_predict(input t_mode mode, input line_ends_t ends);
        voxel_word_t res;
        logic        moves[3];
        int          d;
        res = IDLE_WORD;
        if (mode == MODE_LOAD) begin
            walk_pos[0]  = ends.sx;
            walk_pos[1]  = ends.sy;
            walk_pos[2]  = ends.sz;
            walk_goal[0] = ends.ex;
            walk_goal[1] = ends.ey;
            walk_goal[2] = ends.ez;
            for (int a = 0; a < 3; a++) begin
                d = int'(walk_goal[a]) - int'(walk_pos[a]);
                walk_span[a] = (CB+1)'((d < 0) ? -d : d);
                walk_down[a] = !(walk_pos[a] < walk_goal[a]);
            end
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    cross_term[a][b] = (a != b) ? 64'(walk_span[b]) : 0;
            walk_live = (walk_pos[0] != walk_goal[0]) || (walk_pos[1] != walk_goal[1]) ||
                        (walk_pos[2] != walk_goal[2]);
            return res;
        end
        if (!walk_live)
            return res;
        // an axis steps unless some other axis crosses strictly earlier
        for (int a = 0; a < 3; a++) begin
            moves[a] = 1'b1;
            for (int b = 0; b < 3; b++)
                if (a != b && cross_term[b][a] < cross_term[a][b])
                    moves[a] = 1'b0;
        end
        for (int a = 0; a < 3; a++) begin
            if (moves[a]) begin
                walk_pos[a] = walk_down[a] ? walk_pos[a] - 1'b1 : walk_pos[a] + 1'b1;
                for (int b = 0; b < 3; b++)
                    if (a != b)
                        cross_term[a][b] += 2 * 64'(walk_span[b]);
            end
        end
        res.x     = walk_pos[0];
        res.y     = walk_pos[1];
        res.z     = walk_pos[2];
        res.valid = 1'b1;
        res.last  = (walk_pos[0] == walk_goal[0]) && (walk_pos[1] == walk_goal[1]) &&
                    (walk_pos[2] == walk_goal[2]);
        if (res.last)
            walk_live = 1'b0;
        return res;
    endfunction

    function automatic line_ends_t mk_line(input logic signed [CB-1:0] sx, sy, sz, ex, ey, ez);
        mk_line = '{ez: ez, ey: ey, ex: ex, sz: sz, sy: sy, sx: sx};
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of words with random gaps; predict at acceptance
    // ------------------------------------------------------------------
    task automatic offer_word(input t_mode mode, input line_ends_t ends,
                              input logic typed, input voxel_word_t typed_want);
        voxel_word_t predicted;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= ends;
        s_tuser  <= mode;
        do @(posedge i_clk); while (!s_tready);
        predicted = walk_predict(mode, ends);
        voxels_due.insert(voxels_due.size(), typed ? typed_want : predicted);
        cmds_sent++;
    endtask

    // Hold the sender until every expected word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (voxels_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, long hold-off on request, and checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    int ready_style = 0;
    int style_left = 0;
    int hold_left = 0;
    int tick = 0;

    always @(posedge i_clk) begin
        voxel_word_t got;
        voxel_word_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{x: m_tdata[CB-1:0], y: m_tdata[2*CB-1:CB], z: m_tdata[3*CB-1:2*CB],
                    valid: m_tuser[0], last: m_tlast};
            if (voxels_due.size() == 0) begin
                $error("result word arrived with nothing expected");
                n_errors++;
            end else begin
                want = voxels_due.pop_front();
                check_field("voxel_x", int'(want.x), int'(got.x));
                check_field("voxel_y", int'(want.y), int'(got.y));
                check_field("voxel_z", int'(want.z), int'(got.z));
                check_field("voxel_valid", int'(want.valid), int'(got.valid));
                check_field("last_voxel", int'(want.last), int'(got.last));
            end
        end
        tick++;
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (style_left == 0) begin
            style_left  = $urandom_range(20, 200);
            ready_style = $urandom_range(0, 3);
        end
        style_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (ready_style)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= tick[1];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with no word moving on either side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    dir_row_t dir_rows[DIR_ROWS];

    initial begin
        logic signed [CB-1:0] st[3];
        logic signed [CB-1:0] en[3];
        line_ends_t           ends;
        int                   d;
        int                   kind;
        int                   stop_at;
        int                   n_adv;

        dir_rows = '{
            // advance before any load: invalid word
            '{MODE_ADVANCE, '0, 1'b1, IDLE_WORD},
            // start equals end: nothing to walk
            '{MODE_LOAD, mk_line(0, 0, 0, 0, 0, 0), 1'b1, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b1, IDLE_WORD},
            // single step on x, then the finished line gives an invalid word
            '{MODE_LOAD, mk_line(0, 0, 0, 1, 0, 0), 1'b1, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b1, '{x: 1, y: 0, z: 0, valid: 1'b1, last: 1'b1}},
            '{MODE_ADVANCE, '0, 1'b1, IDLE_WORD},
            // three-way tie at the negative extreme: all axes step together
            '{MODE_LOAD, mk_line(CMIN, CMIN, CMIN, CMIN + 1, CMIN + 1, CMIN + 1),
              1'b1, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b1,
              '{x: CMIN + 1, y: CMIN + 1, z: CMIN + 1, valid: 1'b1, last: 1'b1}},
            // counting down from the positive extreme
            '{MODE_LOAD, mk_line(CMAX, CMAX, CMAX, CMAX - 1, CMAX - 1, CMAX - 2),
              1'b1, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b1, IDLE_WORD},
            // full-range spans on x and y, then a reload in the middle of the walk
            '{MODE_LOAD, mk_line(CMIN, CMAX, 0, CMAX, CMIN, 3), 1'b1, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_LOAD, mk_line(5, -7, 2, 9, -3, -1), 1'b1, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD},
            '{MODE_ADVANCE, '0, 1'b0, IDLE_WORD}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer_word(dir_rows[i].mode, dir_rows[i].ends, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        // long receiver hold-off while the sender keeps pushing
        hold_req = 1'b1;

        while (cmds_sent < DIR_ROWS + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind == 0)
                drain_results();
            if ($urandom_range(0, 299) == 0)
                hold_req = 1'b1;
            for (int a = 0; a < 3; a++) begin
                st[a] = CB'($urandom());
                en[a] = CB'($urandom());
            end
            if (kind >= 90) begin
                // noise: bare advances, whatever the walker state
                repeat ($urandom_range(1, 4))
                    offer_word(MODE_ADVANCE, IN_W'($urandom()), 1'b0, IDLE_WORD);
                continue;
            end
            if (kind < 70) begin
                // short line near a random start
                for (int a = 0; a < 3; a++) begin
                    d = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
                    if ($urandom_range(0, 1)) d = -d;
                    if (int'(st[a]) + d > 32767 || int'(st[a]) + d < -32768) d = -d;
                    en[a] = CB'(int'(st[a]) + d);
                end
            end else if (kind >= 80) begin
                // degenerate: no span at all, or one step on one axis
                for (int a = 0; a < 3; a++) en[a] = st[a];
                if (kind[0]) begin
                    d = $urandom_range(0, 2);
                    en[d] = st[d] ^ 1'b1;
                end
            end
            ends = mk_line(st[0], st[1], st[2], en[0], en[1], en[2]);
            offer_word(MODE_LOAD, ends, 1'b0, IDLE_WORD);
            if (kind < 70 || kind >= 80) begin
                // walk to the end, sometimes cut short by the next load
                stop_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 20) : 1000;
                n_adv = 0;
                while (walk_live && n_adv < stop_at) begin
                    offer_word(MODE_ADVANCE, IN_W'($urandom()), 1'b0, IDLE_WORD);
                    n_adv++;
                end
                repeat ($urandom_range(0, 2))
                    offer_word(MODE_ADVANCE, IN_W'($urandom()), 1'b0, IDLE_WORD);
            end else begin
                repeat ($urandom_range(1, 20))
                    offer_word(MODE_ADVANCE, IN_W'($urandom()), 1'b0, IDLE_WORD);
            end
        end

        drain_results();
        repeat (6) @(posedge i_clk);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
src/vlt3d_pkg.sv
src/voxel_line_traversal_3d_unit.sv
verif/tb.sv
